FILE: hw/rtl/string_key_hash_table_defines.svh
// assertion helpers for the string key hash table
`ifndef STRING_KEY_HASH_TABLE_DEFINES_SVH
`define STRING_KEY_HASH_TABLE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SKHT_ASSERT_NOW(lbl, clk, rstn, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define SKHT_ASSERT_NEXT(lbl, clk, rstn, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/skht_pkg.sv
package skht_pkg;

    localparam int          KEY_WORDS  = 8;
    localparam int          FREQ_W     = 32;
    localparam int          TAG_W      = 56;
    localparam logic [31:0] HASH_INIT  = 32'd2166136261;
    localparam logic [31:0] HASH_PRIME = 32'd16777619;
    localparam logic [TAG_W-1:0] TAG_DEFAULT = 56'h78;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4,
        ST_BAD       = 3'd5
    } status_t;

    // keep tag bytes up to the first zero byte
    function automatic logic [TAG_W-1:0] tidy_tag(input logic [TAG_W-1:0] t);
        logic [TAG_W-1:0] r;
        logic             run;
        r   = '0;
        run = 1'b1;
        for (int i = 0; i < 7; i++) begin
            if (t[8*i +: 8] == 8'd0) begin
                run = 1'b0;
            end
            if (run) begin
                r[8*i +: 8] = t[8*i +: 8];
            end
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/skht_ram.sv
module skht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/skht_mod.sv
module skht_mod #(
    parameter int SLOTS = 1024
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [31:0]              dividend,
    output logic                     done,
    output logic [$clog2(SLOTS)-1:0] rem
);

    localparam int SW = $clog2(SLOTS);
    localparam int SH = 32 + SW;
    // reciprocal rounded up, exact for every 32-bit dividend
    localparam logic [32:0] RECIP = 33'(((65'd1 << SH) + 65'(SLOTS - 1)) / 65'(SLOTS));

    logic          stage1_reg;
    logic          stage2_reg;
    logic          done_reg;
    logic [31:0]   num_reg;
    logic [64:0]   prod_reg;
    logic [SW-1:0] rem_reg;
    logic [31:0]   quo;
    logic [31:0]   back;
    logic [31:0]   diff;

    // quotient from the reciprocal product, then multiply back and subtract
    assign quo  = 32'(prod_reg >> SH);
    assign back = 32'(quo * 32'(SLOTS));
    assign diff = num_reg - back;

    // three stages: capture, reciprocal multiply, remainder
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage1_reg <= 1'b0;
            stage2_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            stage1_reg <= start;
            stage2_reg <= stage1_reg;
            done_reg   <= stage2_reg;
            if (start) begin
                num_reg <= dividend;
            end
            if (stage1_reg) begin
                prod_reg <= 65'(num_reg) * 65'(RECIP);
            end
            if (stage2_reg) begin
                rem_reg <= diff[SW-1:0];
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

FILE: hw/rtl/string_key_hash_table.sv
// flow: one key byte per cycle while gathering; on the last byte the hash modulo runs,
// then each probe is a slot read plus eight key word compares, a new key is then
// written as eight key words, and the result waits in an output register
// throughput: one key at a time; input ready only while gathering key bytes
// reset: synchronous active-low; after reset the used bits are swept clear,
// one slot a cycle, before the first request is taken
`include "string_key_hash_table_defines.svh"

module string_key_hash_table #(
    parameter int SLOTS     = 1024,
    parameter int KEY_BYTES = 63
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // key_byte[7:0], freq[39:8], pos_tag[95:40]
    input  logic         s_tlast,
    input  logic [1:0]   s_tuser,   // func[0], pos_given[1]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // freq_out[31:0], pos_out[87:32], slot[97:88],
                                    // entry_count[108:98], zero [111:109]
    output logic [2:0]   m_tuser    // status[2:0]
);

    import skht_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int LW = $clog2(KEY_BYTES + 2);
    localparam int KW = $clog2(SLOTS * KEY_WORDS);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_MOD, S_RD, S_CMP, S_INS, S_DONE
    } state_t;

    state_t            state_reg;
    logic [SW-1:0]     clr_reg;
    logic [LW-1:0]     len_reg;
    logic [31:0]       hash_reg;
    logic [63:0]       key_buf_reg [KEY_WORDS];
    logic [CW-1:0]     count_reg;
    logic              func_reg;
    logic              given_reg;
    logic [FREQ_W-1:0] freq_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [SW-1:0]     idx_reg;
    logic [SW-1:0]     probe_reg;
    logic [2:0]        wcnt_reg;
    logic [2:0]        dw_reg;
    logic              mism_reg;
    logic              m_tvalid_reg;
    status_t           status_reg;
    logic [FREQ_W-1:0] freq_out_reg;
    logic [TAG_W-1:0]  pos_out_reg;
    logic [9:0]        slot_reg;
    logic [10:0]       ecount_reg;

    // input fields
    logic              in_func;
    logic              in_given;
    logic [7:0]        in_byte;
    logic [FREQ_W-1:0] in_freq;
    logic [TAG_W-1:0]  in_tag;
    logic              s_acc;

    assign in_byte  = s_tdata[7:0];
    assign in_freq  = s_tdata[39:8];
    assign in_tag   = s_tdata[95:40];
    assign in_func  = s_tuser[0];
    assign in_given = s_tuser[1];
    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // byte gathering and fnv-1a step
    logic          len_ok;
    logic          byte_bad;
    logic [LW-1:0] len_after;
    logic [31:0]   hash_step;
    logic          key_bad;

    assign len_ok    = (len_reg <= LW'(KEY_BYTES));
    assign byte_bad  = (in_byte == 8'd0) || (len_reg == LW'(KEY_BYTES));
    assign len_after = !len_ok ? len_reg :
                       (byte_bad ? LW'(KEY_BYTES + 1) : len_reg + 1'b1);
    assign hash_step = 32'((hash_reg ^ {24'd0, in_byte}) * HASH_PRIME);
    assign key_bad   = (len_after > LW'(KEY_BYTES)) || (len_after == '0);

    // modulo unit
    logic          mod_start;
    logic          mod_done;
    logic [SW-1:0] mod_rem;

    assign mod_start = s_acc && s_tlast && !key_bad;

    skht_mod #(.SLOTS(SLOTS)) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .dividend (hash_step),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // stores
    logic              occ_we, occ_wdata, occ_rdata;
    logic [SW-1:0]     occ_waddr;
    logic              key_we;
    logic [63:0]       key_rdata;
    logic              freq_we, tag_we;
    logic [FREQ_W-1:0] freq_rdata;
    logic [TAG_W-1:0]  tag_rdata, tag_wdata;
    logic [63:0]       buf_word;

    // probe decisions
    logic slot_empty, mism_n, last_word, hit, miss_end, upd;

    assign buf_word   = key_buf_reg[dw_reg];
    assign slot_empty = (state_reg == S_CMP) && (dw_reg == 3'd0) && !occ_rdata;
    assign mism_n     = mism_reg || (key_rdata != buf_word);
    assign last_word  = (state_reg == S_CMP) && !slot_empty && (dw_reg == 3'd7);
    assign hit        = last_word && !mism_n;
    assign miss_end   = last_word && mism_n;
    assign upd        = hit && func_reg;

    assign occ_we    = (state_reg == S_CLEAR) || ((state_reg == S_INS) && (dw_reg == 3'd0));
    assign occ_waddr = (state_reg == S_CLEAR) ? clr_reg : idx_reg;
    assign occ_wdata = (state_reg != S_CLEAR);
    assign key_we    = (state_reg == S_INS);
    assign freq_we   = ((state_reg == S_INS) && (dw_reg == 3'd0)) || upd;
    assign tag_we    = ((state_reg == S_INS) && (dw_reg == 3'd0)) || (upd && given_reg);
    assign tag_wdata = (state_reg == S_INS && !given_reg) ? TAG_DEFAULT : tag_reg;

    skht_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_occ (
        .aclk (aclk), .we (occ_we), .waddr (occ_waddr), .wdata (occ_wdata),
        .raddr (idx_reg), .rdata (occ_rdata)
    );

    skht_ram #(.WIDTH(64), .DEPTH(SLOTS * KEY_WORDS)) u_key (
        .aclk (aclk), .we (key_we), .waddr (KW'({idx_reg, dw_reg})),
        .wdata (buf_word), .raddr (KW'({idx_reg, wcnt_reg})), .rdata (key_rdata)
    );

    skht_ram #(.WIDTH(FREQ_W), .DEPTH(SLOTS)) u_freq (
        .aclk (aclk), .we (freq_we), .waddr (idx_reg), .wdata (freq_reg),
        .raddr (idx_reg), .rdata (freq_rdata)
    );

    skht_ram #(.WIDTH(TAG_W), .DEPTH(SLOTS)) u_tag (
        .aclk (aclk), .we (tag_we), .waddr (idx_reg), .wdata (tag_wdata),
        .raddr (idx_reg), .rdata (tag_rdata)
    );

    // sequencer, key gathering and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            len_reg      <= '0;
            hash_reg     <= HASH_INIT;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < KEY_WORDS; i++) begin
                key_buf_reg[i] <= '0;
            end
        end else begin
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == SW'(SLOTS - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_acc) begin
                        len_reg <= len_after;
                        if (len_ok && !byte_bad) begin
                            key_buf_reg[3'(len_reg >> 3)][8*(3'(len_reg)) +: 8] <= in_byte;
                            hash_reg <= hash_step;
                        end
                        if (s_tlast) begin
                            func_reg  <= in_func;
                            given_reg <= in_given;
                            freq_reg  <= in_freq;
                            tag_reg   <= tidy_tag(in_tag);
                            if (key_bad) begin
                                status_reg   <= ST_BAD;
                                freq_out_reg <= '0;
                                pos_out_reg  <= '0;
                                slot_reg     <= '0;
                                ecount_reg   <= 11'(count_reg);
                                m_tvalid_reg <= 1'b1;
                                state_reg    <= S_DONE;
                            end else begin
                                state_reg <= S_MOD;
                            end
                        end
                    end
                end
                S_MOD: begin
                    if (mod_done) begin
                        idx_reg   <= mod_rem;
                        probe_reg <= '0;
                        wcnt_reg  <= '0;
                        state_reg <= S_RD;
                    end
                end
                S_RD: begin
                    wcnt_reg  <= 3'd1;
                    dw_reg    <= 3'd0;
                    mism_reg  <= 1'b0;
                    state_reg <= S_CMP;
                end
                S_CMP: begin
                    if (slot_empty) begin
                        if (func_reg) begin
                            state_reg <= S_INS;
                        end else begin
                            status_reg   <= ST_NOT_FOUND;
                            freq_out_reg <= '0;
                            pos_out_reg  <= '0;
                            slot_reg     <= '0;
                            ecount_reg   <= 11'(count_reg);
                            m_tvalid_reg <= 1'b1;
                            state_reg    <= S_DONE;
                        end
                    end else if (hit) begin
                        status_reg   <= func_reg ? ST_UPDATED : ST_FOUND;
                        freq_out_reg <= func_reg ? freq_reg : freq_rdata;
                        pos_out_reg  <= (func_reg && given_reg) ? tag_reg : tag_rdata;
                        slot_reg     <= 10'(idx_reg);
                        ecount_reg   <= 11'(count_reg);
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_DONE;
                    end else if (miss_end) begin
                        if (probe_reg == SW'(SLOTS - 1)) begin
                            status_reg   <= func_reg ? ST_FULL : ST_NOT_FOUND;
                            freq_out_reg <= '0;
                            pos_out_reg  <= '0;
                            slot_reg     <= '0;
                            ecount_reg   <= 11'(count_reg);
                            m_tvalid_reg <= 1'b1;
                            state_reg    <= S_DONE;
                        end else begin
                            probe_reg <= probe_reg + 1'b1;
                            idx_reg   <= (idx_reg == SW'(SLOTS - 1)) ? '0 : idx_reg + 1'b1;
                            wcnt_reg  <= '0;
                            state_reg <= S_RD;
                        end
                    end else begin
                        mism_reg <= mism_n;
                        dw_reg   <= dw_reg + 3'd1;
                        wcnt_reg <= wcnt_reg + 3'd1;
                    end
                end
                S_INS: begin
                    dw_reg <= dw_reg + 3'd1;
                    if (dw_reg == 3'd0) begin
                        count_reg    <= count_reg + 1'b1;
                        status_reg   <= ST_INSERTED;
                        freq_out_reg <= freq_reg;
                        pos_out_reg  <= given_reg ? tag_reg : TAG_DEFAULT;
                        slot_reg     <= 10'(idx_reg);
                        ecount_reg   <= 11'(count_reg + 1'b1);
                    end
                    if (dw_reg == 3'd7) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hand over the result and ready the next key
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        hash_reg     <= HASH_INIT;
                        len_reg      <= '0;
                        for (int i = 0; i < KEY_WORDS; i++) begin
                            key_buf_reg[i] <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'd0, ecount_reg, slot_reg, pos_out_reg, freq_out_reg};

    `SKHT_ASSERT_NOW(a_one_side_busy, aclk, aresetn, s_tready, !m_tvalid_reg, "request taken while result pending")
    `SKHT_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(SLOTS), "entry count above slot count")
    `SKHT_ASSERT_NEXT(a_insert_counts, aclk, aresetn, (state_reg == S_INS) && (dw_reg == 3'd0), count_reg != $past(count_reg), "insert did not bump count")
    `SKHT_ASSERT_NOW(a_clear_blocks, aclk, aresetn, state_reg == S_CLEAR, !s_tready, "request taken during clearing sweep")

endmodule
